[rtl/core/ggw_pkg.sv]
// Shared types and constants of the greedy word wrap block.
// Used by the front end, the result queue and the back end; no dependencies.

package ggw_pkg;

  // Build-time limits of the row and line counters.
  localparam int unsigned MaxRowChars  = 65536;
  localparam int unsigned MaxLineWidth = 4095;

  localparam logic [15:0] POS_CAP =
      16'(((MaxRowChars - 1) > 65535) ? 65535 : (MaxRowChars - 1));
  localparam logic [11:0] WIDTH_CAP =
      12'((MaxLineWidth > 4095) ? 4095 : MaxLineWidth);

  localparam logic [20:0] SEPARATOR     = 21'h000020;
  localparam logic [12:0] WORD_LEN_MAX  = 13'h1FFF;
  localparam logic [11:0] SPAN_MAX      = 12'hFFF;
  localparam logic [11:0] WIDTH_RESET   = 12'd80;
  localparam int unsigned MAX_RESULTS   = 4;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);

  // One wrapped line.
  typedef struct packed {
    logic        fin;
    logic [11:0] len;
    logic [15:0] start;
  } line_res_t;

  // All results caused by one input word, in order from index 0.
  typedef struct packed {
    line_res_t [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0]            cnt;
  } bundle_t;

endpackage

[rtl/core/ggw_front.sv]
// Front end of the greedy word wrap: holds the width register and row state,
// takes input characters and turns word decisions into result bundles.
// Depends on ggw_pkg.

module ggw_front
  import ggw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [11:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [20:0]      code_point_i,
  input  logic             last_in_row_i,
  input  logic             empty_row_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output bundle_t          push_data_o
);

  typedef struct packed {
    logic [15:0]     ls;
    logic [11:0]     used;
    logic            has;
    logic [1:0]      n;
    line_res_t [1:0] r;
  } decide_t;

  // Stage register: results of the separator decision plus the operands of
  // the end-of-row decision, which is resolved from this register.
  typedef struct packed {
    logic [1:0]      n;
    line_res_t [1:0] r;
    logic            fin_en;
    logic [15:0]     fin_s;
    logic [12:0]     fin_len;
    logic [15:0]     fin_ls;
    logic [11:0]     fin_used;
    logic            fin_has;
    logic [11:0]     fin_w;
  } stage_t;

  function automatic logic [15:0] pos_inc(input logic [15:0] p);
    return (p >= POS_CAP) ? POS_CAP : p + 16'd1;
  endfunction

  function automatic logic [11:0] span(input logic [15:0] from, input logic [16:0] to);
    logic [16:0] d;
    d = (to > {1'b0, from}) ? to - {1'b0, from} : 17'd0;
    return (d > 17'(SPAN_MAX)) ? SPAN_MAX : d[11:0];
  endfunction

  function automatic line_res_t mk(input logic [15:0] s, input logic [11:0] l,
                                   input logic f);
    line_res_t r;
    r.start = s;
    r.len   = l;
    r.fin   = f;
    return r;
  endfunction

  function automatic decide_t decide(input logic [15:0] ls, input logic [11:0] used,
                                     input logic has, input logic [11:0] w,
                                     input logic [15:0] s, input logic [12:0] len,
                                     input logic last);
    decide_t     d;
    logic [13:0] sum;
    logic [15:0] ls_fit;
    logic [15:0] s_prev;
    logic [16:0] s_end;
    logic        idx;
    d.ls   = ls;
    d.used = used;
    d.has  = has;
    d.n    = 2'd0;
    d.r    = '0;
    sum    = 14'(used) + 14'(len) + 14'(has);
    ls_fit = has ? ls : s;
    s_end  = 17'(s) + 17'(len);
    s_prev = (s != 16'd0) ? s - 16'd1 : 16'd0;
    idx    = has;
    if (w != 12'd0) begin
      if (sum <= 14'(w)) begin
        d.ls   = ls_fit;
        d.used = sum[11:0];
        d.has  = 1'b1;
        if (last) begin
          d.r[0] = mk(ls_fit, span(ls_fit, s_end), 1'b1);
          d.n    = 2'd1;
        end
      end else begin
        // The open line is closed just before the separator that precedes s.
        if (has) begin
          d.r[0] = mk(ls, span(ls, {1'b0, s_prev}), 1'b0);
          d.n    = 2'd1;
        end
        if (len < 13'(w)) begin
          d.ls   = s;
          d.used = len[11:0];
          d.has  = 1'b1;
          if (last) begin
            d.r[idx] = mk(s, len[11:0], 1'b1);
            d.n      = d.n + 2'd1;
          end
        end else begin
          // An overlong word is cut to the line width on a line of its own.
          d.r[idx] = mk(s, w, last);
          d.n      = d.n + 2'd1;
          d.ls     = s;
          d.used   = 12'd0;
          d.has    = 1'b0;
        end
      end
    end
    return d;
  endfunction

  logic [11:0] lw_q, lw_d;
  logic [15:0] cp_q, cp_d;
  logic [15:0] ws_q, ws_d;
  logic [12:0] wl_q, wl_d;
  logic [15:0] ls_q, ls_d;
  logic [11:0] lu_q, lu_d;
  logic        has_q, has_d;
  logic        stg_valid_q, stg_valid_d;
  stage_t      stg_q, stg_d;

  logic        in_fire;
  logic        adv;
  logic [11:0] w_eff;
  logic        is_sep;
  decide_t     sep_dec;
  decide_t     fin_dec;
  logic [15:0] ws_nx;
  logic [12:0] wl_nx;
  logic [CNT_W-1:0] total;

  assign w_eff   = (lw_q > WIDTH_CAP) ? WIDTH_CAP : lw_q;
  assign is_sep  = (code_point_i == SEPARATOR);
  assign sep_dec = decide(ls_q, lu_q, has_q, w_eff, ws_q, wl_q, 1'b0);
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    lw_d        = cfg_we_i ? cfg_wdata_i : lw_q;
    cp_d        = cp_q;
    ws_d        = ws_q;
    wl_d        = wl_q;
    ls_d        = ls_q;
    lu_d        = lu_q;
    has_d       = has_q;
    stg_d       = stg_q;
    ws_nx       = ws_q;
    wl_nx       = wl_q;
    stg_valid_d = stg_valid_q;
    if (adv) begin
      stg_valid_d = 1'b0;
    end
    if (in_fire) begin
      stg_valid_d = 1'b1;
      stg_d       = '0;
      if (empty_row_i) begin
        cp_d  = 16'd0;
        ws_d  = 16'd0;
        wl_d  = 13'd0;
        ls_d  = 16'd0;
        lu_d  = 12'd0;
        has_d = 1'b0;
        if (w_eff != 12'd0) begin
          stg_d.r[0] = mk(16'd0, 12'd0, 1'b1);
          stg_d.n    = 2'd1;
        end
      end else begin
        if (is_sep) begin
          ls_d    = sep_dec.ls;
          lu_d    = sep_dec.used;
          has_d   = sep_dec.has;
          stg_d.n = sep_dec.n;
          stg_d.r = sep_dec.r;
          ws_nx   = pos_inc(cp_q);
          wl_nx   = 13'd0;
        end else if (wl_q < WORD_LEN_MAX) begin
          wl_nx = wl_q + 13'd1;
        end
        cp_d = pos_inc(cp_q);
        ws_d = ws_nx;
        wl_d = wl_nx;
        if (last_in_row_i) begin
          stg_d.fin_en   = 1'b1;
          stg_d.fin_s    = ws_nx;
          stg_d.fin_len  = wl_nx;
          stg_d.fin_ls   = ls_d;
          stg_d.fin_used = lu_d;
          stg_d.fin_has  = has_d;
          stg_d.fin_w    = w_eff;
          cp_d  = 16'd0;
          ws_d  = 16'd0;
          wl_d  = 13'd0;
          ls_d  = 16'd0;
          lu_d  = 12'd0;
          has_d = 1'b0;
        end
      end
    end
  end

  // End-of-row decision on the staged operands; its line state is dropped.
  assign fin_dec = decide(stg_q.fin_ls, stg_q.fin_used, stg_q.fin_has, stg_q.fin_w,
                          stg_q.fin_s, stg_q.fin_len, 1'b1);

  always_comb begin
    total = CNT_W'(stg_q.n);
    if (stg_q.fin_en) begin
      total = total + CNT_W'(fin_dec.n);
    end
  end

  always_comb begin
    push_data_o     = '0;
    push_data_o.cnt = total;
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < stg_q.n) begin
        push_data_o.res[k] = stg_q.r[k];
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (stg_q.fin_en && (2'(k) < fin_dec.n)) begin
        push_data_o.res[stg_q.n + 2'(k)] = fin_dec.r[k];
      end
    end
  end

  assign push_valid_o = stg_valid_q && (total != '0);
  assign adv          = stg_valid_q && ((total == '0) || push_ready_i);
  assign in_ready_o   = !stg_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q        <= WIDTH_RESET;
      cp_q        <= 16'd0;
      ws_q        <= 16'd0;
      wl_q        <= 13'd0;
      ls_q        <= 16'd0;
      lu_q        <= 12'd0;
      has_q       <= 1'b0;
      stg_valid_q <= 1'b0;
    end else begin
      lw_q        <= lw_d;
      cp_q        <= cp_d;
      ws_q        <= ws_d;
      wl_q        <= wl_d;
      ls_q        <= ls_d;
      lu_q        <= lu_d;
      has_q       <= has_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

`ifndef ASSERT_OFF
  a_bundle_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
      push_valid_o |-> (push_data_o.cnt <= CNT_W'(MAX_RESULTS)))
    else $error("result bundle larger than four lines");
`endif

endmodule

[rtl/core/ggw_queue.sv]
// Short queue of result bundles between the front end and the back end.
// Depends on ggw_pkg for the bundle type.

module ggw_queue
  import ggw_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output logic    head_valid_o,
  output bundle_t head_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t         mem_q [DEPTH];
  logic [AW-1:0]   wr_q, wr_d;
  logic [AW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push;

  assign push_ready_o = (cnt_q < CW'(DEPTH));
  assign push         = push_valid_i && push_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= CW'(DEPTH))
    else $error("queue count exceeds depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");
`endif

endmodule

[rtl/core/ggw_back.sv]
// Back end of the greedy word wrap: unpacks queued bundles into the output
// register, one line per cycle while the receiver does not stall. Depends on ggw_pkg.

module ggw_back
  import ggw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  bundle_t     head_data_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] start_offset, [27:16] line_length
  output logic        m_axis_tlast,   // row_finished
  output logic        m_axis_tuser    // last_of_run
);

  localparam int unsigned KW = $clog2(MAX_RESULTS);

  logic [KW-1:0] k_q, k_d;
  logic          ov_q, ov_d;
  line_res_t     res_q;
  logic          lor_q;
  logic          load;
  logic          at_end;
  line_res_t     cur;

  assign cur    = head_data_i.res[k_q];
  assign at_end = (CNT_W'(k_q) == (head_data_i.cnt - CNT_W'(1)));
  assign load   = head_valid_i && (!ov_q || m_axis_tready);
  assign pop_o  = load && at_end;

  always_comb begin
    k_d  = k_q;
    ov_d = ov_q;
    if (m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d = 1'b1;
      k_d  = at_end ? '0 : k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= cur;
      lor_q <= at_end;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, res_q.len, res_q.start};
  assign m_axis_tlast  = res_q.fin;
  assign m_axis_tuser  = lor_q;

`ifndef ASSERT_OFF
  // The final line of a row is always the last line caused by its word.
  a_fin_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("row end not at end of run");
`endif

endmodule

[rtl/core/greedy_word_wrap.sv]
// Top level of the greedy word wrap block: front end, bundle queue, back end.
// Depends on ggw_pkg, ggw_front, ggw_queue and ggw_back.
//
// Usage: characters of a text row enter on the s_axis channel, one character per
// handshake; tlast marks the final character of the row and tuser marks an
// empty row. Each wrapped line leaves on the m_axis channel as a start offset
// and a length; tlast flags the final line of the row and tuser the final
// line caused by the input word. The line width is to be written through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce
// this. Zero suppresses all output. Throughput: one input character per cycle
// while the queue has room. The front end decides the separator word in the
// accept cycle and the end-of-row word in the next, then pushes up to four lines
// as one bundle into a QUEUE_DEPTH deep queue. The back end drains one line per
// cycle while the receiver accepts; lines pass the stage register, the queue and
// the output register. When the receiver stalls the output register holds, the
// queue fills, and s_axis_tready drops only when the queue is full. Reset empties
// the pipeline, clears the row state and sets the line width to 80.

module greedy_word_wrap
  import ggw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] code_point
  input  logic        s_axis_tlast,   // last_in_row
  input  logic        s_axis_tuser,   // empty_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] start_offset, [27:16] line_length
  output logic        m_axis_tlast,   // row_finished
  output logic        m_axis_tuser    // last_of_run
);

  logic    push_valid;
  logic    push_ready;
  bundle_t push_data;
  logic    pop;
  logic    head_valid;
  bundle_t head_data;

  ggw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .code_point_i  (s_axis_tdata[20:0]),
    .last_in_row_i (s_axis_tlast),
    .empty_row_i   (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  ggw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  ggw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_data_i   (head_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
